// File: hdl/jump_address_mode_unit_assert.svh
// ---------------------------------------------------------------------------
// jump_address_mode_unit_assert.svh
// Assertion macros for the jump address mode unit; empty when
// NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef JUMP_ADDRESS_MODE_UNIT_ASSERT_SVH
`define JUMP_ADDRESS_MODE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Clocked check, off while reset is applied
`define JAMU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
// Clocked check that also holds during reset
`define JAMU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define JAMU_ASSERT(lbl, prop, msg)
`define JAMU_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: hdl/jamu_pkg.sv
// ---------------------------------------------------------------------------
// jamu_pkg
// Widths and codes shared by the jump address mode unit and its interfaces.
// ---------------------------------------------------------------------------
package jamu_pkg;

  // Field widths
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned REG_W  = 3;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned NUM_REGS = 8;

  // Commands
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EVAL  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_REPLY = 2'd3;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_JUMP    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DATA    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ILLEGAL = 2'd3;

  // Addressing modes
  localparam logic [MODE_W-1:0] MODE_ILLEGAL   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REG       = 3'd1;
  localparam logic [MODE_W-1:0] MODE_AUTOINC   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_AUTOINC_D = 3'd3;
  localparam logic [MODE_W-1:0] MODE_AUTODEC   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_AUTODEC_D = 3'd5;
  localparam logic [MODE_W-1:0] MODE_INDEX     = 3'd6;
  localparam logic [MODE_W-1:0] MODE_INDEX_D   = 3'd7;

  // Fixed values
  localparam logic [REG_W-1:0]  PC_INDEX       = 3'd7;
  localparam logic [WORD_W-1:0] ILLEGAL_VECTOR = 16'hF014;
  localparam logic [WORD_W-1:0] WORD_STEP      = 16'd2;

endpackage

// File: hdl/jamu_if.sv
// ---------------------------------------------------------------------------
// jamu_if
// Valid/ready channels of the jump address mode unit: command items in,
// result items out.
// ---------------------------------------------------------------------------
interface jamu_in_if;
  logic                          valid;
  logic                          ready;
  logic [jamu_pkg::CMD_W-1:0]    command;
  logic [jamu_pkg::MODE_W-1:0]   mode;
  logic [jamu_pkg::REG_W-1:0]    reg_select;
  logic [jamu_pkg::WORD_W-1:0]   value;

  modport source (output valid, command, mode, reg_select, value, input ready);
  modport sink   (input valid, command, mode, reg_select, value, output ready);
endinterface

interface jamu_out_if;
  logic                          valid;
  logic                          ready;
  logic [jamu_pkg::KIND_W-1:0]   kind;
  logic [jamu_pkg::WORD_W-1:0]   word;

  modport source (output valid, kind, word, input ready);
  modport sink   (input valid, kind, word, output ready);
endinterface

// File: hdl/jump_address_mode_unit.sv
// ---------------------------------------------------------------------------
// jump_address_mode_unit
// Jump target calculation for a 16-bit, eight-register machine (R7 program
// counter), with register file access and memory word fetch.
// ---------------------------------------------------------------------------
// One item is taken every clock cycle while the unit does not stall. An item is
// captured in an input register, then decoded and executed from there (register
// file read, one 16-bit add, one register write), and its result, if any, lands
// in an output register, from which it is presented on the output channel.
// Input and output sides decouple through the output register: a new item is
// taken while a result waits, and the unit stalls only when the waiting result
// is not taken and the next item also produces one. Memory words are fetched by
// emitting a read request result and taking the data back as a reply item;
// memory latency is entirely outside the unit. Register writes give no result,
// replies while idle are dropped, and a new evaluate abandons a pending one.
// ---------------------------------------------------------------------------
`include "jump_address_mode_unit_assert.svh"

module jump_address_mode_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  jamu_in_if.sink      in_i,
  jamu_out_if.source   out_o
);

  // Wait phase codes
  localparam logic [1:0] PHASE_IDLE  = 2'd0;
  localparam logic [1:0] PHASE_INDEX = 2'd1;
  localparam logic [1:0] PHASE_FINAL = 2'd2;
  localparam logic [1:0] PHASE_SPARE = 2'd3;

  // Input register
  logic                           in_valid_q;
  logic [jamu_pkg::CMD_W-1:0]     in_cmd_q;
  logic [jamu_pkg::MODE_W-1:0]    in_mode_q;
  logic [jamu_pkg::REG_W-1:0]     in_reg_q;
  logic [jamu_pkg::WORD_W-1:0]    in_value_q;

  // Architectural state
  logic [jamu_pkg::WORD_W-1:0]    rf_q [jamu_pkg::NUM_REGS];
  logic [1:0]                     phase_q, phase_d;
  logic [jamu_pkg::MODE_W-1:0]    held_mode_q, held_mode_d;
  logic [jamu_pkg::REG_W-1:0]     held_reg_q, held_reg_d;

  // Output register
  logic                           out_valid_q;
  logic [jamu_pkg::KIND_W-1:0]    out_kind_q;
  logic [jamu_pkg::WORD_W-1:0]    out_word_q;

  // Execute stage signals
  logic                           out_free;
  logic                           advance;
  logic                           has_res;
  logic [jamu_pkg::KIND_W-1:0]    res_kind;
  logic [jamu_pkg::WORD_W-1:0]    res_word;
  logic                           wr_en;
  logic [jamu_pkg::REG_W-1:0]     wr_addr;
  logic [jamu_pkg::WORD_W-1:0]    wr_data;
  logic [jamu_pkg::REG_W-1:0]     rd_addr;
  logic [jamu_pkg::WORD_W-1:0]    rd_data;
  logic [jamu_pkg::WORD_W-1:0]    pc_data;
  logic [jamu_pkg::WORD_W-1:0]    rd_inc;
  logic [jamu_pkg::WORD_W-1:0]    rd_dec;
  logic [jamu_pkg::WORD_W-1:0]    pc_inc;
  logic [jamu_pkg::WORD_W-1:0]    idx_sum;

  // Handshake: execute when the result slot can take what the item gives
  assign out_free = !out_valid_q || out_o.ready;
  assign advance  = in_valid_q && (!has_res || out_free);
  assign in_i.ready = !in_valid_q || advance;

  assign out_o.valid = out_valid_q;
  assign out_o.kind  = out_kind_q;
  assign out_o.word  = out_word_q;

  // Register file read: replies use the held register, all else the selected one
  assign rd_addr = (in_cmd_q == jamu_pkg::CMD_REPLY) ? held_reg_q : in_reg_q;
  assign rd_data = rf_q[rd_addr];
  assign pc_data = rf_q[jamu_pkg::PC_INDEX];
  assign rd_inc  = rd_data + jamu_pkg::WORD_STEP;
  assign rd_dec  = rd_data - jamu_pkg::WORD_STEP;
  assign pc_inc  = pc_data + jamu_pkg::WORD_STEP;
  assign idx_sum = in_value_q + rd_data;

  // Command decode and execute
  always_comb begin
    has_res     = 1'b0;
    res_kind    = jamu_pkg::KIND_JUMP;
    res_word    = rd_data;
    wr_en       = 1'b0;
    wr_addr     = in_reg_q;
    wr_data     = in_value_q;
    phase_d     = phase_q;
    held_mode_d = held_mode_q;
    held_reg_d  = held_reg_q;
    unique case (in_cmd_q)
      jamu_pkg::CMD_WRITE: begin
        wr_en = 1'b1;
      end
      jamu_pkg::CMD_READ: begin
        has_res  = 1'b1;
        res_kind = jamu_pkg::KIND_DATA;
      end
      jamu_pkg::CMD_EVAL: begin
        phase_d     = PHASE_IDLE;
        held_mode_d = in_mode_q;
        held_reg_d  = in_reg_q;
        has_res     = 1'b1;
        unique case (in_mode_q) inside
          jamu_pkg::MODE_ILLEGAL: begin
            res_kind = jamu_pkg::KIND_ILLEGAL;
            res_word = jamu_pkg::ILLEGAL_VECTOR;
          end
          jamu_pkg::MODE_REG: begin
            res_kind = jamu_pkg::KIND_JUMP;
          end
          jamu_pkg::MODE_AUTOINC: begin
            wr_en   = 1'b1;
            wr_data = rd_inc;
          end
          jamu_pkg::MODE_AUTOINC_D: begin
            wr_en    = 1'b1;
            wr_data  = rd_inc;
            res_kind = jamu_pkg::KIND_READ;
            phase_d  = PHASE_FINAL;
          end
          jamu_pkg::MODE_AUTODEC: begin
            wr_en    = 1'b1;
            wr_data  = rd_dec;
            res_word = rd_dec;
          end
          jamu_pkg::MODE_AUTODEC_D: begin
            wr_en    = 1'b1;
            wr_data  = rd_dec;
            res_kind = jamu_pkg::KIND_READ;
            res_word = rd_dec;
            phase_d  = PHASE_FINAL;
          end
          jamu_pkg::MODE_INDEX, jamu_pkg::MODE_INDEX_D: begin
            // fetch the index word at the program counter
            wr_en    = 1'b1;
            wr_addr  = jamu_pkg::PC_INDEX;
            wr_data  = pc_inc;
            res_kind = jamu_pkg::KIND_READ;
            res_word = pc_data;
            phase_d  = PHASE_INDEX;
          end
          default: begin
            has_res = 1'b0;
          end
        endcase
      end
      jamu_pkg::CMD_REPLY: begin
        phase_d = PHASE_IDLE;
        unique case (phase_q)
          PHASE_INDEX: begin
            has_res  = 1'b1;
            res_word = idx_sum;
            if (held_mode_q == jamu_pkg::MODE_INDEX_D) begin
              res_kind = jamu_pkg::KIND_READ;
              phase_d  = PHASE_FINAL;
            end
          end
          PHASE_FINAL: begin
            has_res  = 1'b1;
            res_word = in_value_q;
          end
          default: begin
            // reply with nothing pending is dropped
            has_res = 1'b0;
          end
        endcase
      end
      default: begin
        has_res = 1'b0;
      end
    endcase
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_cmd_q   <= in_i.command;
      in_mode_q  <= in_i.mode;
      in_reg_q   <= in_i.reg_select;
      in_value_q <= in_i.value;
    end
  end

  // Register file and evaluation state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < jamu_pkg::NUM_REGS; i++) begin
        rf_q[i] <= '0;
      end
      phase_q     <= PHASE_IDLE;
      held_mode_q <= '0;
      held_reg_q  <= '0;
    end else if (advance) begin
      if (wr_en) begin
        rf_q[wr_addr] <= wr_data;
      end
      phase_q     <= phase_d;
      held_mode_q <= held_mode_d;
      held_reg_q  <= held_reg_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && has_res) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && has_res) begin
      out_kind_q <= res_kind;
      out_word_q <= res_word;
    end
  end

  // Checks
  `JAMU_ASSERT(a_no_overwrite, !(advance && has_res) || out_free,
    "result register overwritten while a result waits")
  `JAMU_ASSERT(a_index_mode,
    (phase_q != PHASE_INDEX) || (held_mode_q == jamu_pkg::MODE_INDEX) ||
    (held_mode_q == jamu_pkg::MODE_INDEX_D),
    "waiting for an index word outside an indexed mode")
  `JAMU_ASSERT(a_illegal_result,
    (advance && (in_cmd_q == jamu_pkg::CMD_EVAL) &&
     (in_mode_q == jamu_pkg::MODE_ILLEGAL)) |=>
    (out_valid_q && (out_kind_q == jamu_pkg::KIND_ILLEGAL) &&
     (out_word_q == jamu_pkg::ILLEGAL_VECTOR) && (phase_q == PHASE_IDLE)),
    "illegal mode did not yield the illegal vector")
  `JAMU_ASSERT(a_reg_write,
    (advance && (in_cmd_q == jamu_pkg::CMD_WRITE)) |=>
    (rf_q[$past(in_reg_q)] == $past(in_value_q)),
    "register write not applied")
  `JAMU_ASSERT_ALWAYS(a_phase_legal, !rst_ni || (phase_q != PHASE_SPARE),
    "wait phase left its legal codes")

endmodule

// File: sim/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for jump_address_mode_unit. A short table of directed
// items covers every addressing mode, the wrap points of the 16-bit sums and
// the corner cases: a reply while idle, an evaluate that abandons a pending
// one, and a register write while a reply is awaited. Random jump sequences
// with memory replies, register traffic and noise follow. Every accepted item
// goes through a mirror of the register file and the wait phase. Result items
// are checked in order against the predicted ones, with random stalls on both
// channels and one long output hold-off.
// ---------------------------------------------------------------------------
module testbench;

  localparam int CLK_PERIOD  = 10;
  localparam int ITEM_TARGET = 1650;
  localparam int TAIL_ITEMS  = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 300;
  localparam int DRAIN_WAIT  = 12;
  localparam int MAX_PRINTS  = 40;
  localparam int TIMEOUT     = 5_000_000;

  typedef enum logic [1:0] {PH_IDLE, PH_INDEX, PH_FINAL} wait_phase_e;
  typedef enum logic [1:0] {CHK_MODEL, CHK_RESULT, CHK_NONE} row_check_e;

  typedef struct packed {
    logic [jamu_pkg::CMD_W-1:0]  command;
    logic [jamu_pkg::MODE_W-1:0] mode;
    logic [jamu_pkg::REG_W-1:0]  rsel;
    logic [jamu_pkg::WORD_W-1:0] value;
  } cmd_item_t;

  typedef struct packed {
    logic [jamu_pkg::KIND_W-1:0] kind;
    logic [jamu_pkg::WORD_W-1:0] word;
  } unit_result_t;

  typedef struct packed {
    cmd_item_t    item;
    row_check_e   check;
    unit_result_t result;
  } table_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  jamu_in_if  cmd_if ();
  jamu_out_if res_if ();

  jump_address_mode_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Mirror of the unit's state
  logic [jamu_pkg::WORD_W-1:0] reg_mirror [jamu_pkg::NUM_REGS] = '{default: '0};
  wait_phase_e                 mirror_phase = PH_IDLE;
  logic [jamu_pkg::MODE_W-1:0] mirror_mode  = '0;
  logic [jamu_pkg::REG_W-1:0]  mirror_reg   = '0;

  unit_result_t awaited_results [$];
  int           error_count  = 0;
  int           useful_items = 0;
  int           send_idle_pct = 0;

  // Side info riding along with each item: typed expectation of table rows
  row_check_e   row_check;
  unit_result_t row_result;

  // Directed items; typed results only where obvious from the mode
  table_row_t directed_rows [25] = '{
    '{'{jamu_pkg::CMD_READ,  jamu_pkg::MODE_REG,       3'd0, 16'h0000}, CHK_RESULT,
      '{jamu_pkg::KIND_DATA, 16'h0000}},
    '{'{jamu_pkg::CMD_EVAL,  jamu_pkg::MODE_ILLEGAL,   3'd5, 16'hFFFF}, CHK_RESULT,
      '{jamu_pkg::KIND_ILLEGAL, jamu_pkg::ILLEGAL_VECTOR}},
    '{'{jamu_pkg::CMD_REPLY, jamu_pkg::MODE_INDEX_D,   3'd7, 16'h1234}, CHK_NONE,
      '{jamu_pkg::KIND_JUMP, 16'h0000}},
    '{'{jamu_pkg::CMD_WRITE, jamu_pkg::MODE_REG,       3'd1, 16'hFFFF}, CHK_NONE,
      '{jamu_pkg::KIND_JUMP, 16'h0000}},
    '{'{jamu_pkg::CMD_READ,  jamu_pkg::MODE_REG,       3'd1, 16'h0000}, CHK_RESULT,
      '{jamu_pkg::KIND_DATA, 16'hFFFF}},
    '{'{jamu_pkg::CMD_EVAL,  jamu_pkg::MODE_REG,       3'd1, 16'h0000}, CHK_RESULT,
      '{jamu_pkg::KIND_JUMP, 16'hFFFF}},
    '{'{jamu_pkg::CMD_EVAL,  jamu_pkg::MODE_AUTOINC,   3'd1, 16'h0000}, CHK_RESULT,
      '{jamu_pkg::KIND_JUMP, 16'hFFFF}},
    '{'{jamu_pkg::CMD_EVAL,  jamu_pkg::MODE_AUTODEC,   3'd1, 16'h0000}, CHK_RESULT,
      '{jamu_pkg::KIND_JUMP, 16'hFFFF}},
    '{'{jamu_pkg::CMD_EVAL,  jamu_pkg::MODE_AUTOINC_D, 3'd2, 16'h0000}, CHK_RESULT,
      '{jamu_pkg::KIND_READ, 16'h0000}},
    '{'{jamu_pkg::CMD_REPLY, jamu_pkg::MODE_REG,       3'd0, 16'hFFFF}, CHK_RESULT,
      '{jamu_pkg::KIND_JUMP, 16'hFFFF}},
    '{'{jamu_pkg::CMD_EVAL,  jamu_pkg::MODE_AUTODEC_D, 3'd2, 16'h0000}, CHK_RESULT,
      '{jamu_pkg::KIND_READ, 16'h0000}},
    '{'{jamu_pkg::CMD_REPLY, jamu_pkg::MODE_REG,       3'd0, 16'h0000}, CHK_RESULT,
      '{jamu_pkg::KIND_JUMP, 16'h0000}},
    '{'{jamu_pkg::CMD_WRITE, jamu_pkg::MODE_REG,       3'd7, 16'hFFFE}, CHK_NONE,
      '{jamu_pkg::KIND_JUMP, 16'h0000}},
    '{'{jamu_pkg::CMD_EVAL,  jamu_pkg::MODE_INDEX,     3'd7, 16'h0000}, CHK_MODEL,
      '{jamu_pkg::KIND_JUMP, 16'h0000}},
    '{'{jamu_pkg::CMD_REPLY, jamu_pkg::MODE_REG,       3'd0, 16'hFFFF}, CHK_MODEL,
      '{jamu_pkg::KIND_JUMP, 16'h0000}},
    '{'{jamu_pkg::CMD_EVAL,  jamu_pkg::MODE_INDEX_D,   3'd6, 16'h0000}, CHK_MODEL,
      '{jamu_pkg::KIND_JUMP, 16'h0000}},
    '{'{jamu_pkg::CMD_WRITE, jamu_pkg::MODE_REG,       3'd6, 16'h8000}, CHK_NONE,
      '{jamu_pkg::KIND_JUMP, 16'h0000}},
    '{'{jamu_pkg::CMD_REPLY, jamu_pkg::MODE_REG,       3'd0, 16'h7FFF}, CHK_MODEL,
      '{jamu_pkg::KIND_JUMP, 16'h0000}},
    '{'{jamu_pkg::CMD_REPLY, jamu_pkg::MODE_REG,       3'd0, 16'h1234}, CHK_MODEL,
      '{jamu_pkg::KIND_JUMP, 16'h0000}},
    '{'{jamu_pkg::CMD_EVAL,  jamu_pkg::MODE_INDEX,     3'd3, 16'h0000}, CHK_MODEL,
      '{jamu_pkg::KIND_JUMP, 16'h0000}},
    '{'{jamu_pkg::CMD_EVAL,  jamu_pkg::MODE_REG,       3'd3, 16'h0000}, CHK_MODEL,
      '{jamu_pkg::KIND_JUMP, 16'h0000}},
    '{'{jamu_pkg::CMD_REPLY, jamu_pkg::MODE_REG,       3'd0, 16'h5555}, CHK_NONE,
      '{jamu_pkg::KIND_JUMP, 16'h0000}},
    '{'{jamu_pkg::CMD_EVAL,  jamu_pkg::MODE_AUTOINC_D, 3'd7, 16'h0000}, CHK_MODEL,
      '{jamu_pkg::KIND_JUMP, 16'h0000}},
    '{'{jamu_pkg::CMD_REPLY, jamu_pkg::MODE_REG,       3'd0, 16'hAAAA}, CHK_MODEL,
      '{jamu_pkg::KIND_JUMP, 16'h0000}},
    '{'{jamu_pkg::CMD_EVAL,  jamu_pkg::MODE_AUTODEC,   3'd0, 16'h0000}, CHK_MODEL,
      '{jamu_pkg::KIND_JUMP, 16'h0000}}
  };

  // Next state and result of the unit for one item; returns 1 if a result comes
  function automatic bit compute_jump_result(input cmd_item_t it,
                                             output unit_result_t res);
    logic [jamu_pkg::WORD_W-1:0] addr;
    res = '{jamu_pkg::KIND_JUMP, '0};
    case (it.command)
      jamu_pkg::CMD_WRITE: begin
        reg_mirror[it.rsel] = it.value;
        return 1'b0;
      end
      jamu_pkg::CMD_READ: begin
        res = '{jamu_pkg::KIND_DATA, reg_mirror[it.rsel]};
        return 1'b1;
      end
      jamu_pkg::CMD_EVAL: begin
        mirror_phase = PH_IDLE;
        mirror_mode  = it.mode;
        mirror_reg   = it.rsel;
        case (it.mode)
          jamu_pkg::MODE_ILLEGAL:
            res = '{jamu_pkg::KIND_ILLEGAL, jamu_pkg::ILLEGAL_VECTOR};
          jamu_pkg::MODE_REG:
            res = '{jamu_pkg::KIND_JUMP, reg_mirror[it.rsel]};
          jamu_pkg::MODE_AUTOINC: begin
            res = '{jamu_pkg::KIND_JUMP, reg_mirror[it.rsel]};
            reg_mirror[it.rsel] += jamu_pkg::WORD_STEP;
          end
          jamu_pkg::MODE_AUTOINC_D: begin
            res = '{jamu_pkg::KIND_READ, reg_mirror[it.rsel]};
            reg_mirror[it.rsel] += jamu_pkg::WORD_STEP;
            mirror_phase = PH_FINAL;
          end
          jamu_pkg::MODE_AUTODEC: begin
            reg_mirror[it.rsel] -= jamu_pkg::WORD_STEP;
            res = '{jamu_pkg::KIND_JUMP, reg_mirror[it.rsel]};
          end
          jamu_pkg::MODE_AUTODEC_D: begin
            reg_mirror[it.rsel] -= jamu_pkg::WORD_STEP;
            res = '{jamu_pkg::KIND_READ, reg_mirror[it.rsel]};
            mirror_phase = PH_FINAL;
          end
          default: begin
            // indexed modes fetch the index word at the PC
            res = '{jamu_pkg::KIND_READ, reg_mirror[jamu_pkg::PC_INDEX]};
            reg_mirror[jamu_pkg::PC_INDEX] += jamu_pkg::WORD_STEP;
            mirror_phase = PH_INDEX;
          end
        endcase
        return 1'b1;
      end
      default: begin
        case (mirror_phase)
          PH_INDEX: begin
            addr = it.value + reg_mirror[mirror_reg];
            if (mirror_mode == jamu_pkg::MODE_INDEX_D) begin
              mirror_phase = PH_FINAL;
              res = '{jamu_pkg::KIND_READ, addr};
            end else begin
              mirror_phase = PH_IDLE;
              res = '{jamu_pkg::KIND_JUMP, addr};
            end
            return 1'b1;
          end
          PH_FINAL: begin
            mirror_phase = PH_IDLE;
            res = '{jamu_pkg::KIND_JUMP, it.value};
            return 1'b1;
          end
          default: begin
            mirror_phase = PH_IDLE;
            return 1'b0;
          end
        endcase
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [jamu_pkg::WORD_W-1:0] got,
                                 input logic [jamu_pkg::WORD_W-1:0] want);
    if (error_count < MAX_PRINTS)
      $display("%0t: mismatch in %s: got %h, want %h", $time, what, got, want);
    error_count++;
  endtask

  function automatic bit in_tail();
    return useful_items >= ITEM_TARGET - TAIL_ITEMS;
  endfunction

  // Words biased toward the wrap points
  function automatic logic [jamu_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'hFFFE;
      3:       return 16'h8000;
      4:       return 16'h7FFF;
      default: return jamu_pkg::WORD_W'($urandom);
    endcase
  endfunction

  // Check results, then mirror accepted items
  always @(posedge clk_i) begin : scoreboard
    unit_result_t predicted;
    unit_result_t oldest;
    cmd_item_t    taken;
    bit           produced;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result item", res_if.word, '0);
        end else begin
          oldest = awaited_results.pop_front();
          if (res_if.kind != oldest.kind)
            report_mismatch("kind", jamu_pkg::WORD_W'(res_if.kind),
                            jamu_pkg::WORD_W'(oldest.kind));
          if (res_if.word != oldest.word)
            report_mismatch("word", res_if.word, oldest.word);
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        taken = '{cmd_if.command, cmd_if.mode, cmd_if.reg_select, cmd_if.value};
        if (!(taken.command == jamu_pkg::CMD_REPLY && mirror_phase == PH_IDLE))
          useful_items++;
        produced = compute_jump_result(taken, predicted);
        case (row_check)
          CHK_MODEL:  if (produced) awaited_results.push_back(predicted);
          CHK_RESULT: awaited_results.push_back(row_result);
          default: ;
        endcase
      end
    end
  end

  // Offer one item after an optional idle burst; returns at its accepting edge
  task automatic send_item(input logic [jamu_pkg::CMD_W-1:0]  command,
                           input logic [jamu_pkg::MODE_W-1:0] mode,
                           input logic [jamu_pkg::REG_W-1:0]  rsel,
                           input logic [jamu_pkg::WORD_W-1:0] value,
                           input row_check_e check = CHK_MODEL,
                           input unit_result_t want = '0);
    if (!in_tail() && $urandom_range(0, 99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.command    <= command;
    cmd_if.mode       <= mode;
    cmd_if.reg_select <= rsel;
    cmd_if.value      <= value;
    row_check         <= check;
    row_result        <= want;
    do @(posedge clk_i); while (!cmd_if.ready);
  endtask

  // One random jump sequence, register access or noise item
  task automatic send_random_sequence();
    logic [jamu_pkg::MODE_W-1:0] mode;
    int                          replies;
    int                          pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      mode = jamu_pkg::MODE_W'($urandom_range(0, 7));
      send_item(jamu_pkg::CMD_EVAL, mode, jamu_pkg::REG_W'($urandom_range(0, 7)),
                jamu_pkg::WORD_W'($urandom));
      case (mode)
        jamu_pkg::MODE_AUTOINC_D, jamu_pkg::MODE_AUTODEC_D, jamu_pkg::MODE_INDEX:
          replies = 1;
        jamu_pkg::MODE_INDEX_D:
          replies = 2;
        default:
          replies = 0;
      endcase
      // cut short, so the next evaluate abandons it, or a stray reply
      if (replies > 0 && $urandom_range(0, 9) == 0) replies--;
      else if ($urandom_range(0, 19) == 0) replies++;
      repeat (replies) begin
        if ($urandom_range(0, 6) == 0)
          send_item($urandom_range(0, 1) ? jamu_pkg::CMD_WRITE : jamu_pkg::CMD_READ,
                    jamu_pkg::MODE_W'($urandom_range(0, 7)),
                    jamu_pkg::REG_W'($urandom_range(0, 7)), pick_word());
        send_item(jamu_pkg::CMD_REPLY, jamu_pkg::MODE_W'($urandom_range(0, 7)),
                  jamu_pkg::REG_W'($urandom_range(0, 7)), pick_word());
      end
    end else if (pick < 82) begin
      send_item(jamu_pkg::CMD_WRITE, jamu_pkg::MODE_W'($urandom_range(0, 7)),
                jamu_pkg::REG_W'($urandom_range(0, 7)), pick_word());
    end else if (pick < 92) begin
      send_item(jamu_pkg::CMD_READ, jamu_pkg::MODE_W'($urandom_range(0, 7)),
                jamu_pkg::REG_W'($urandom_range(0, 7)), jamu_pkg::WORD_W'($urandom));
    end else begin
      send_item(jamu_pkg::CMD_W'($urandom_range(0, 3)),
                jamu_pkg::MODE_W'($urandom_range(0, 7)),
                jamu_pkg::REG_W'($urandom_range(0, 7)), jamu_pkg::WORD_W'($urandom));
    end
  endtask

  // Result side: random stall bursts, one long hold-off, none in the tail
  initial begin : result_sink
    int  stall_pct;
    int  cycles;
    bit  hold_done;
    stall_pct = 0;
    cycles    = 0;
    hold_done = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles % 256 == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 10;
          default: stall_pct = 30;
        endcase
      end
      if (!hold_done && useful_items >= HOLD_AFTER) begin
        hold_done = 1'b1;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        res_if.ready <= 1'b1;
      end else if (rst_ni && !in_tail() && $urandom_range(0, 99) < stall_pct) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Reset, directed table, random sequences, drain
  initial begin : stimulus
    int seq_count;
    seq_count = 0;
    rst_ni            <= 1'b0;
    cmd_if.valid      <= 1'b0;
    cmd_if.command    <= jamu_pkg::CMD_WRITE;
    cmd_if.mode       <= jamu_pkg::MODE_ILLEGAL;
    cmd_if.reg_select <= '0;
    cmd_if.value      <= '0;
    row_check         <= CHK_MODEL;
    row_result        <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_item(directed_rows[i].item.command, directed_rows[i].item.mode,
                directed_rows[i].item.rsel, directed_rows[i].item.value,
                directed_rows[i].check, directed_rows[i].result);

    while (useful_items < ITEM_TARGET) begin
      if (seq_count % 16 == 0) begin
        case ($urandom_range(0, 3))
          0, 1:    send_idle_pct = 0;
          2:       send_idle_pct = 15;
          default: send_idle_pct = 40;
        endcase
      end
      send_random_sequence();
      seq_count++;
    end
    cmd_if.valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (error_count == 0 && awaited_results.size() == 0)
      $display("** jump_address_mode_unit: PASSED **");
    else
      $display("** jump_address_mode_unit: FAILED **");
    $finish;
  end

  // Hang guard
  initial begin : watchdog
    #(TIMEOUT);
    $display("** jump_address_mode_unit: FAILED **");
    $finish;
  end

endmodule
